>>> src/sstf_pkg.sv
// Shared types and constants for the shortest-seek-first request scheduler.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps

package sstf_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TRACK_W     = 16;
    localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Widths fixed by the external interface.
    localparam int ID_W    = 8;
    localparam int PTRK_W  = 16;
    localparam int LIM_W   = 5;
    localparam int OCC_W   = 5;
    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(16);

    localparam logic ACT_INSERT  = 1'b0;
    localparam logic ACT_SERVICE = 1'b1;

    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_SERVICED = 2'd1,
        STAT_REJECTED = 2'd2,
        STAT_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    requester;
        logic [TRACK_W-1:0] track;
    } entry_t;

endpackage

>>> src/sstf_disk_request_scheduler.sv
// Top level of the shortest-seek-first disk request scheduler: sequencer,
// registers and result stage. Depends on sstf_pkg, sstf_store and sstf_dist.
`timescale 1ns / 1ps

// The block keeps up to QUEUE_DEPTH pending disk requests and a head track.
// Requests arrive on the s_ channel (valid/ready). An insert request appends
// an entry unless the table holds min(queue_limit, QUEUE_DEPTH) entries, in
// which case it is rejected. A service request removes the entry nearest the
// head, the newest one on a tie, and moves the head to its track.
// Every request yields exactly one result on the m_ channel (valid/ready).
// s_ready is high only while the sequencer is idle; one request is in work at
// a time. A reject or an empty service passes through the response step to
// raise m_valid, an insert through the insert step and then the response
// step; s_ready returns together with m_valid. A service runs the scan
// through the single memory read port and the shared distance unit, then
// closes the gap left by the removed entry on the same port, moving each
// newer entry one place down, and the response step loads the output
// register.
// The result sits in an output register; while the receiver stalls the
// sequencer holds the next result and accepts nothing new. The user must
// write queue_limit through cfg_wr_en/cfg_wr_data only while idle; the block
// does not enforce this. Reset (aresetn low, synchronous) empties the table,
// puts the head on track 0 and the limit to 16; no clearing pass is needed.
module sstf_disk_request_scheduler (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sstf_pkg::LIM_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [sstf_pkg::ID_W-1:0]     s_requester_id,
    input  logic [sstf_pkg::PTRK_W-1:0]   s_track,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic [sstf_pkg::ID_W-1:0]     m_served_requester,
    output logic [sstf_pkg::PTRK_W-1:0]   m_served_track,
    output logic [sstf_pkg::OCC_W-1:0]    m_occupancy
);
    import sstf_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TRACK_W-1:0]  head_reg, head_next;
    logic [LIM_W-1:0]    limit_reg;
    logic [ID_W-1:0]     req_reg, req_next;
    logic [TRACK_W-1:0]  trk_reg, trk_next;
    status_t             status_reg, status_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                pipe_vld_reg, pipe_vld_next;
    logic [ADDR_W-1:0]   pipe_idx_reg, pipe_idx_next;
    logic [ADDR_W-1:0]   best_idx_reg, best_idx_next;
    logic [TRACK_W-1:0]  best_d_reg, best_d_next;
    logic [ID_W-1:0]     best_req_reg, best_req_next;
    logic [TRACK_W-1:0]  best_trk_reg, best_trk_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_req_reg, m_req_next;
    logic [PTRK_W-1:0]   m_trk_reg, m_trk_next;
    logic [OCC_W-1:0]    m_occ_reg, m_occ_next;

    logic                accept;
    logic                full;
    logic                issue;
    logic                walk_done;
    logic                out_free;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    entry_t              mem_wdata;
    entry_t              mem_rdata;
    logic [TRACK_W-1:0]  cur_d;
    logic                cur_take;

    assign accept    = s_valid && s_ready;
    // Full against the configured limit saturated to the table depth.
    assign full      = (32'(count_reg) >= 32'(limit_reg)) ||
                       (32'(count_reg) >= 32'(QUEUE_DEPTH));
    // A memory read is issued while the walk index is inside the table.
    assign issue     = ((state_reg == S_SCAN) || (state_reg == S_SHIFT)) &&
                       (idx_reg < count_reg);
    assign walk_done = !issue && !pipe_vld_reg;
    assign out_free  = !m_valid_reg || m_ready;

    sstf_store u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (mem_rdata)
    );

    sstf_dist u_dist (
        .head   (head_reg),
        .track  (mem_rdata.track),
        .best_d (best_d_reg),
        .first  (pipe_idx_reg == '0),
        .seek_d (cur_d),
        .take   (cur_take)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_INSERT) begin
                        state_next = full ? S_RESP : S_INSERT;
                    end else begin
                        state_next = (count_reg == '0) ? S_RESP : S_SCAN;
                    end
                end
            end
            S_INSERT: state_next = S_RESP;
            S_SCAN: begin
                if (walk_done) begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (walk_done) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and memory write port.
    always_comb begin
        s_ready   = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = count_reg[ADDR_W-1:0];
        mem_wdata = '{requester: req_reg, track: trk_reg};
        case (state_reg)
            S_IDLE:   s_ready = 1'b1;
            S_INSERT: mem_we  = 1'b1;
            S_SHIFT: begin
                // Move the entry read last cycle one place toward the oldest end.
                mem_we    = pipe_vld_reg;
                mem_waddr = pipe_idx_reg - ADDR_W'(1);
                mem_wdata = mem_rdata;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb begin
        count_next    = count_reg;
        head_next     = head_reg;
        req_next      = req_reg;
        trk_next      = trk_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = pipe_idx_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        best_req_next = best_req_reg;
        best_trk_next = best_trk_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_req_next    = m_req_reg;
        m_trk_next    = m_trk_reg;
        m_occ_next    = m_occ_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next      = s_requester_id;
                    trk_next      = s_track[TRACK_W-1:0];
                    idx_next      = '0;
                    best_req_next = '0;
                    best_trk_next = '0;
                    if (s_action == ACT_INSERT) begin
                        status_next = full ? STAT_REJECTED : STAT_INSERTED;
                    end else begin
                        status_next = (count_reg == '0) ? STAT_EMPTY : STAT_SERVICED;
                    end
                end
            end
            S_INSERT: count_next = count_reg + CNT_W'(1);
            S_SCAN: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                pipe_vld_next = issue;
                pipe_idx_next = idx_reg[ADDR_W-1:0];
                if (pipe_vld_reg && cur_take) begin
                    best_idx_next = pipe_idx_reg;
                    best_d_next   = cur_d;
                    best_req_next = mem_rdata.requester;
                    best_trk_next = mem_rdata.track;
                end
                if (walk_done) begin
                    idx_next = CNT_W'(best_idx_reg) + CNT_W'(1);
                end
            end
            S_SHIFT: begin
                if (issue) begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                pipe_vld_next = issue;
                pipe_idx_next = idx_reg[ADDR_W-1:0];
                if (walk_done) begin
                    count_next = count_reg - CNT_W'(1);
                    head_next  = best_trk_reg;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_req_next    = best_req_reg;
                    m_trk_next    = PTRK_W'(best_trk_reg);
                    m_occ_next    = OCC_W'(count_reg);
                end
            end
            default: begin
                pipe_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            head_reg     <= '0;
            limit_reg    <= LIMIT_RESET;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            head_reg     <= head_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        trk_reg      <= trk_next;
        status_reg   <= status_next;
        idx_reg      <= idx_next;
        pipe_idx_reg <= pipe_idx_next;
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        best_req_reg <= best_req_next;
        best_trk_reg <= best_trk_next;
        m_status_reg <= m_status_next;
        m_req_reg    <= m_req_next;
        m_trk_reg    <= m_trk_next;
        m_occ_reg    <= m_occ_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_served_requester = m_req_reg;
    assign m_served_track     = m_trk_reg;
    assign m_occupancy        = m_occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(QUEUE_DEPTH))
        else $error("pending count exceeds table depth");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |-> (32'(count_reg) < 32'(QUEUE_DEPTH)))
        else $error("insert write with a full table");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("pending count moved by more than one");

    a_scan_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_vld_reg && (state_reg == S_SCAN)) |->
            (CNT_W'(pipe_idx_reg) < count_reg))
        else $error("scan read beyond the pending entries");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_RESP))
        else $error("result raised outside the response step");
`endif

endmodule

>>> src/sstf_store.sv
// Request table memory: one write port and one registered read port.
// Depends on sstf_pkg for the entry type and address width.
`timescale 1ns / 1ps

module sstf_store (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [sstf_pkg::ADDR_W-1:0]  wr_addr,
    input  sstf_pkg::entry_t             wr_data,
    input  logic [sstf_pkg::ADDR_W-1:0]  rd_addr,
    output sstf_pkg::entry_t             rd_data
);
    import sstf_pkg::*;

    entry_t mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> src/sstf_dist.sv
// Shared seek-distance unit: absolute track distance and best-so-far compare.
// Depends on sstf_pkg for the track width.
`timescale 1ns / 1ps

module sstf_dist (
    input  logic [sstf_pkg::TRACK_W-1:0] head,
    input  logic [sstf_pkg::TRACK_W-1:0] track,
    input  logic [sstf_pkg::TRACK_W-1:0] best_d,
    input  logic                         first,
    output logic [sstf_pkg::TRACK_W-1:0] seek_d,
    output logic                         take
);
    import sstf_pkg::*;

    always_comb begin
        seek_d = (head >= track) ? (head - track) : (track - head);
        // The table is scanned oldest first, so ties go to the later entry.
        take = first || (seek_d <= best_d);
    end

endmodule

>>> sim/sstf_disk_request_scheduler_tb.sv
// Self-checking testbench for the shortest-seek-first disk request scheduler.
// Depends on sstf_pkg and sstf_disk_request_scheduler, which needs sstf_store and sstf_dist.
`timescale 1ns / 1ps

module sstf_disk_request_scheduler_tb;

    import sstf_pkg::*;

    // Slack after the last result. Every request yields a result, so this only
    // catches stray results that come too late.
    localparam int SETTLE_CYCLES = 8;
    // Bound on waiting for outstanding results at a drain point. At most one
    // result waits in the output register and one request is in work, behind
    // receiver stall runs that may follow one another.
    localparam int DRAIN_LIMIT   = 5000;

    // One result as the block should return it.
    typedef struct {
        status_t             status;
        logic [ID_W-1:0]     requester;
        logic [PTRK_W-1:0]   track;
        logic [OCC_W-1:0]    occupancy;
    } sched_outcome_t;

    logic                aclk               = 1'b0;
    logic                aresetn            = 1'b0;
    logic                cfg_wr_en          = 1'b0;
    logic [LIM_W-1:0]    cfg_wr_data        = '0;
    logic                s_valid            = 1'b0;
    logic                s_ready;
    logic                s_action           = ACT_INSERT;
    logic [ID_W-1:0]     s_requester_id     = '0;
    logic [PTRK_W-1:0]   s_track            = '0;
    logic                m_valid;
    logic                m_ready            = 1'b0;
    logic [1:0]          m_status;
    logic [ID_W-1:0]     m_served_requester;
    logic [PTRK_W-1:0]   m_served_track;
    logic [OCC_W-1:0]    m_occupancy;

    // Shadow of the block: pending requests newest first, the head position and
    // the limit register as last written.
    entry_t              pending_table[$];
    logic [TRACK_W-1:0]  head_pos  = '0;
    logic [LIM_W-1:0]    limit_reg = LIMIT_RESET;

    // Results owed by the block, oldest at the front.
    sched_outcome_t      awaited_results[$];

    int error_count   = 0;
    int status_tally[4];
    int limit_writes  = 0;

    // Sender pacing: requests left in the current burst.
    int burst_left    = 0;

    // Receiver stall pattern state.
    int rx_mode       = 0;
    int rx_mode_left  = 0;
    int rx_phase      = 0;
    int rx_stall      = 0;

    sched_outcome_t      want;

    sstf_disk_request_scheduler dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_requester_id     (s_requester_id),
        .s_track            (s_track),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_served_requester (m_served_requester),
        .m_served_track     (m_served_track),
        .m_occupancy        (m_occupancy)
    );

    always #5 aclk = ~aclk;

    // Applies one accepted request to the shadow state and returns the result
    // that the block must produce for it.
    function automatic sched_outcome_t schedule_request(input logic act,
            input logic [ID_W-1:0] id, input logic [PTRK_W-1:0] trk);
        sched_outcome_t r;
        entry_t         e;
        int             cap;
        int             best;
        int unsigned    best_gap;
        int unsigned    gap;
        r.status    = STAT_INSERTED;
        r.requester = '0;
        r.track     = '0;
        // Limits above the table depth behave as a full-depth limit.
        cap = (int'(limit_reg) > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
        if (act == ACT_INSERT) begin
            if (pending_table.size() >= cap) begin
                r.status = STAT_REJECTED;
            end else begin
                e.requester = id;
                e.track     = TRACK_W'(trk);
                pending_table.push_front(e);
            end
        end else if (pending_table.size() == 0) begin
            // Head and table stay as they are.
            r.status = STAT_EMPTY;
        end else begin
            // The scan runs from newest to oldest and only a strictly nearer
            // entry replaces the current pick, so a tie keeps the newest entry.
            best     = 0;
            best_gap = 0;
            for (int i = 0; i < pending_table.size(); i++) begin
                gap = (pending_table[i].track > head_pos) ?
                      pending_table[i].track - head_pos :
                      head_pos - pending_table[i].track;
                if (i == 0 || gap < best_gap) begin
                    best     = i;
                    best_gap = gap;
                end
            end
            r.status    = STAT_SERVICED;
            r.requester = pending_table[best].requester;
            r.track     = PTRK_W'(pending_table[best].track);
            head_pos    = pending_table[best].track;
            pending_table.delete(best);
        end
        r.occupancy = OCC_W'(pending_table.size());
        return r;
    endfunction

    // Offers one request and waits for the edge that accepts it. Valid stays
    // high into the next request while a burst lasts; otherwise it drops for a
    // random gap. Callers send the next request or drain without letting time
    // pass, so valid never lingers high over an edge with a stale payload.
    task automatic send_request(input logic act, input logic [ID_W-1:0] id,
            input logic [PTRK_W-1:0] trk);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_requester_id <= id;
        s_track        <= trk;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        awaited_results.push_back(schedule_request(act, id, trk));
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            // Short gaps tend to land inside the block's own processing, long ones
            // may leave it idle before the next request.
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(10, 45)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 4)) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) :
                                                       $urandom_range(0, 4);
        end else begin
            burst_left--;
        end
    endtask

    // Stops sending and waits until every owed result has been taken, so the
    // block is idle and the limit register may be written.
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (awaited_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (awaited_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     awaited_results.size());
            error_count += awaited_results.size();
            awaited_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_queue_limit(input logic [LIM_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        limit_reg = value;
        limit_writes++;
        cfg_wr_en   <= 1'b0;
    endtask

    // Right after reset the table is empty; the id and track of a service
    // request carry no meaning and are set to all ones here.
    task automatic test_empty_service();
        send_request(ACT_SERVICE, 8'hFF, 16'hFFFF);
    endtask

    // Extreme ids and tracks. With the head at 0, track 0 wins first, then
    // the head jumps across the whole disk to the last track.
    task automatic test_track_extremes();
        send_request(ACT_INSERT, 8'h00, 16'hFFFF);
        send_request(ACT_INSERT, 8'hFF, 16'h0000);
        send_request(ACT_SERVICE, 8'h5A, 16'h1234);
        send_request(ACT_SERVICE, 8'hA5, 16'hEDCB);
    endtask

    // Head moves to 100; tracks 90 and 110 then sit at equal distance, and 110
    // appears twice. The newest of the equally near entries has to go first,
    // then the duplicate at distance zero, then the far side.
    task automatic test_nearest_tie();
        send_request(ACT_INSERT, 8'd1, 16'd100);
        send_request(ACT_SERVICE, 8'd0, 16'd0);
        send_request(ACT_INSERT, 8'd2, 16'd90);
        send_request(ACT_INSERT, 8'd3, 16'd110);
        send_request(ACT_INSERT, 8'd4, 16'd110);
        send_request(ACT_SERVICE, 8'd77, 16'd5);
        send_request(ACT_SERVICE, 8'd78, 16'd6);
        send_request(ACT_SERVICE, 8'd79, 16'd7);
    endtask

    // A zero limit rejects everything. Then the limit is lowered below the
    // current count: inserts bounce until services bring the count under it,
    // and the entries already held survive the change.
    task automatic test_queue_limits();
        wait_idle();
        write_queue_limit(LIM_W'(0));
        send_request(ACT_INSERT, 8'd5, 16'd200);
        send_request(ACT_SERVICE, 8'd0, 16'd0);
        wait_idle();
        write_queue_limit(LIM_W'(2));
        send_request(ACT_INSERT, 8'd6, 16'd300);
        send_request(ACT_INSERT, 8'd7, 16'd400);
        wait_idle();
        write_queue_limit(LIM_W'(1));
        send_request(ACT_INSERT, 8'd8, 16'd500);
        send_request(ACT_SERVICE, 8'd0, 16'd0);
        send_request(ACT_INSERT, 8'd9, 16'd600);
        send_request(ACT_SERVICE, 8'd0, 16'd0);
        send_request(ACT_INSERT, 8'd10, 16'd700);
    endtask

    // Random traffic in phases, one limit setting per phase, the extremes
    // among them (zero, one, the table depth and the saturating maximum).
    // Within a phase the mix of inserts and services swings between filling,
    // draining and balanced, so the table often runs full and empty. Tracks
    // come from the whole range, from a coarse grid with repeats, or close to
    // the head so that distances tie.
    task automatic test_random_traffic();
        int                limits[8];
        int                phase_len;
        int                mix_left;
        int                insert_pct;
        int                t;
        logic              act;
        logic [ID_W-1:0]   id;
        logic [PTRK_W-1:0] trk;
        limits     = '{31, 0, 16, 0, 0, 0, 1, 31};
        limits[1]  = $urandom_range(1, 15);
        limits[3]  = $urandom_range(17, 30);
        limits[5]  = $urandom_range(2, 6);
        mix_left   = 0;
        insert_pct = 50;
        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_queue_limit(LIM_W'(limits[p]));
            phase_len = (limits[p] == 0) ? 30 : 103;
            for (int n = 0; n < phase_len; n++) begin
                if (mix_left == 0) begin
                    mix_left = $urandom_range(8, 40);
                    case ($urandom_range(0, 2))
                        0: insert_pct = 85;
                        1: insert_pct = 20;
                        default: insert_pct = 55;
                    endcase
                end
                mix_left--;
                act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_SERVICE;
                id  = ID_W'($urandom_range(0, 255));
                case ($urandom_range(0, 3))
                    0, 1: trk = PTRK_W'($urandom_range(0, (1 << PTRK_W) - 1));
                    2: trk = ($urandom_range(0, 16) == 16) ? '1 :
                             PTRK_W'($urandom_range(0, 15) << 12);
                    default: begin
                        t = int'(head_pos) + int'($urandom_range(0, 8)) - 4;
                        if (t < 0) begin
                            t = 0;
                        end else if (t > (1 << PTRK_W) - 1) begin
                            t = (1 << PTRK_W) - 1;
                        end
                        trk = PTRK_W'(t);
                    end
                endcase
                send_request(act, id, trk);
            end
        end
    endtask

    // Receiver: the pattern changes at random between always ready, random
    // drops, a fixed duty cycle, and bursts of long stalls.
    always @(posedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(50, 400);
        end
        rx_mode_left--;
        rx_phase++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= ((rx_phase % 5) < 2);
            default: begin
                if (rx_stall == 0 && $urandom_range(0, 5) == 0) begin
                    rx_stall = $urandom_range(3, 15);
                end
                if (rx_stall != 0) begin
                    rx_stall--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // Result checker: every result taken from the block must match the oldest
    // owed result in every field.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: status %0d requester %0d track %0d occ %0d",
                         $time, m_status, m_served_requester, m_served_track, m_occupancy);
            end else begin
                want = awaited_results.pop_front();
                status_tally[want.status]++;
                if (m_status !== want.status || m_served_requester !== want.requester ||
                        m_served_track !== want.track || m_occupancy !== want.occupancy) begin
                    error_count++;
                    $display("%0t: mismatch: expected status %s requester %0d track %0d occ %0d",
                             $time, want.status.name(), want.requester, want.track,
                             want.occupancy);
                    $display("%0t:           actual   status %0d requester %0d track %0d occ %0d",
                             $time, m_status, m_served_requester, m_served_track,
                             m_occupancy);
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_service();
        test_track_extremes();
        test_nearest_tie();
        test_queue_limits();
        test_random_traffic();
        wait_idle();
        $display("Covered %0d results: %0d inserted, %0d serviced, %0d rejected, %0d empty.",
                 status_tally[STAT_INSERTED] + status_tally[STAT_SERVICED] +
                 status_tally[STAT_REJECTED] + status_tally[STAT_EMPTY],
                 status_tally[STAT_INSERTED], status_tally[STAT_SERVICED],
                 status_tally[STAT_REJECTED], status_tally[STAT_EMPTY]);
        $display("Queue limit written %0d times; %0d errors found.", limit_writes, error_count);
        if (error_count == 0) begin
            $display("sstf_disk_request_scheduler_tb passed");
        end else begin
            $display("sstf_disk_request_scheduler_tb failed");
        end
        $finish;
    end

    // Watchdog: a correct run needs only a small fraction of this.
    initial begin
        #5ms;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("sstf_disk_request_scheduler_tb failed");
        $finish;
    end

endmodule
